// ----- src/okvt_pkg.sv -----
// shared types and constants for the ordered key/value table
package okvt_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int OP_W    = 3;
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int TOTAL_W = 5;

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_UPDATE   = 3'd1;
	localparam logic [OP_W-1:0] OP_UPSERT   = 3'd2;
	localparam logic [OP_W-1:0] OP_ERASE    = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_POS = 3'd5;

	typedef struct packed {
		logic push;
		logic pull;
		logic upd;
	} okvt_ctl_t;

endpackage

// ----- src/okvt_req_if.sv -----
// request channel of the ordered key/value table
interface okvt_req_if;
	import okvt_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;

	modport source (output valid, op, key, value, position, input ready);
	modport sink (input valid, op, key, value, position, output ready);
endinterface

// ----- src/okvt_rsp_if.sv -----
// response channel of the ordered key/value table
interface okvt_rsp_if;
	import okvt_pkg::*;

	logic               valid;
	logic               ready;
	logic               success;
	logic               table_full;
	logic [KEY_W-1:0]   found_key;
	logic [VALUE_W-1:0] found_value;
	logic [TOTAL_W-1:0] entry_total;

	modport source (output valid, success, table_full, found_key, found_value, entry_total,
		input ready);
	modport sink (input valid, success, table_full, found_key, found_value, entry_total,
		output ready);
endinterface

// ----- src/okvt_cell.sv -----
// one table slot: holds a key and value, compares, and shifts with its neighbors
module okvt_cell #(
	parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  okvt_pkg::okvt_ctl_t   ctl,
	input  logic                  occupied,
	input  logic [KEY_BITS-1:0]   req_key,
	input  logic [VALUE_BITS-1:0] req_value,
	input  logic [KEY_BITS-1:0]   prev_key,
	input  logic [VALUE_BITS-1:0] prev_value,
	input  logic [KEY_BITS-1:0]   next_key,
	input  logic [VALUE_BITS-1:0] next_value,
	input  logic                  seen_in,
	output logic                  seen_out,
	output logic                  match,
	output logic [KEY_BITS-1:0]   key_q,
	output logic [VALUE_BITS-1:0] value_q
);
	import okvt_pkg::*;

	assign match    = occupied && (key_q == req_key);
	assign seen_out = seen_in || match;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end else if (ctl.pull && seen_out) begin
			key_q   <= next_key;
			value_q <= next_value;
		end else if (ctl.upd && match) begin
			value_q <= req_value;
		end
	end
endmodule

// ----- src/ordered_key_value_table.sv -----
// ordered key/value table: a chain of slots, newest entry in slot 0, one request per cycle unless stalled
// response: an accepted request is held in the request register, then its result goes to the response register
// throughput: one request per cycle unless the response is stalled; every slot compares in parallel
// and a match flag ripples down the slot chain to steer erase shifts in the same cycle
// reset: entry count and channel valids clear at once; slot contents are not reset
module ordered_key_value_table #(
	parameter int CAPACITY   = okvt_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	okvt_req_if.sink     req,
	okvt_rsp_if.source   rsp
);
	import okvt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic                  valid_s1;
	logic [OP_W-1:0]       op_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [POS_W-1:0]      pos_s1;

	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	logic                  success_q;
	logic                  full_q;
	logic [KEY_W-1:0]      fkey_q;
	logic [VALUE_W-1:0]    fvalue_q;

	logic                  commit;
	logic                  present;
	logic                  is_full;
	okvt_ctl_t             ctl;
	logic                  ok;
	logic                  refused_full;
	logic [KEY_BITS-1:0]   fk;
	logic [VALUE_BITS-1:0] fv;
	logic                  pos_hit;

	logic [CAPACITY-1:0]   occ;
	logic [CAPACITY-1:0]   match;
	logic [CAPACITY-1:0]   rd_sel;
	logic [CAPACITY:0]     seen;
	logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
	logic [VALUE_BITS-1:0] cell_value [CAPACITY];

	assign commit    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || commit;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1    <= req.op;
			key_s1   <= KEY_BITS'(req.key);
			value_s1 <= VALUE_BITS'(req.value);
			pos_s1   <= req.position;
		end
	end

	// slot chain
	assign seen[0] = 1'b0;
	assign present = seen[CAPACITY];
	assign is_full = (int'(count_q) >= CAPACITY);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]   pk;
		logic [VALUE_BITS-1:0] pv;
		logic [KEY_BITS-1:0]   nk;
		logic [VALUE_BITS-1:0] nv;

		assign occ[i] = (int'(count_q) > i);
		assign rd_sel[i] = ((op_s1 == OP_LOOKUP) && match[i]) ||
			((op_s1 == OP_READ_POS) && occ[i] && (int'(pos_s1) == i));

		if (i == 0) begin : g_first
			assign pk = key_s1;
			assign pv = value_s1;
		end else begin : g_mid
			assign pk = cell_key[i-1];
			assign pv = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign nk = cell_key[i];
			assign nv = cell_value[i];
		end else begin : g_inner
			assign nk = cell_key[i+1];
			assign nv = cell_value[i+1];
		end

		okvt_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ[i]),
			.req_key    (key_s1),
			.req_value  (value_s1),
			.prev_key   (pk),
			.prev_value (pv),
			.next_key   (nk),
			.next_value (nv),
			.seen_in    (seen[i]),
			.seen_out   (seen[i+1]),
			.match      (match[i]),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i])
		);
	end

	// readout of the selected slot
	always_comb begin
		fk = '0;
		fv = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			fk = fk | (cell_key[i] & {KEY_BITS{rd_sel[i]}});
			fv = fv | (cell_value[i] & {VALUE_BITS{rd_sel[i]}});
		end
	end

	assign pos_hit = |rd_sel;

	// operation decode
	always_comb begin
		ctl          = '0;
		ok           = 1'b0;
		refused_full = 1'b0;
		case (op_s1)
			OP_INSERT, OP_UPSERT: begin
				if (present) begin
					if (op_s1 == OP_UPSERT) begin
						ctl.upd = commit;
						ok      = 1'b1;
					end
				end else if (!is_full) begin
					ctl.push = commit;
					ok       = 1'b1;
				end else begin
					refused_full = 1'b1;
				end
			end
			OP_UPDATE: begin
				ctl.upd = commit && present;
				ok      = present;
			end
			OP_ERASE: begin
				ctl.pull = commit && present;
				ok       = present;
			end
			OP_LOOKUP: begin
				ok = present;
			end
			OP_READ_POS: begin
				ok = pos_hit;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// entry count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.pull) begin
				count_q <= count_q - CW'(1);
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			success_q <= ok;
			full_q    <= refused_full;
			fkey_q    <= KEY_W'(fk);
			fvalue_q  <= VALUE_W'(fv);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.success     = success_q;
	assign rsp.table_full  = full_q;
	assign rsp.found_key   = fkey_q;
	assign rsp.found_value = fvalue_q;
	assign rsp.entry_total = TOTAL_W'(count_q);
endmodule
